@@ hw/rtl/crsg_pkg.sv @@
// Shared package for the clipped rectangle span generator.
// Holds command codes, register indexes and stream field positions.
// No dependencies.
`default_nettype none

package crsg_pkg;

    // Item kind on the command stream; span op codes reuse the first three.
    typedef enum logic [1:0] {
        KIND_FILL  = 2'd0,
        KIND_BLIT  = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_ROW   = 2'd3
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ENABLED = 2'd0,
        CFG_WIDTH   = 2'd1,
        CFG_HEIGHT  = 2'd2,
        CFG_PITCH   = 2'd3
    } t_cfg_idx;

    localparam int BYTES_PER_PIXEL = 4;
    localparam int PIX_SHIFT       = $clog2(BYTES_PER_PIXEL);

    localparam int CFG_DATA_W = 16;

    // Input tdata layout.
    localparam int IN_TDATA_W = 160;

    // Output tdata layout, lowest bit first.
    localparam int SHADOW_W   = 24;
    localparam int DEV_W      = 28;
    localparam int SRC_W      = 48;
    localparam int LEN_W      = 13;
    localparam int COLOR_W    = 32;
    localparam int SHADOW_LSB = 0;
    localparam int DEV_LSB    = SHADOW_LSB + SHADOW_W;
    localparam int SRC_LSB    = DEV_LSB + DEV_W;
    localparam int LEN_LSB    = SRC_LSB + SRC_W;
    localparam int COLOR_LSB  = LEN_LSB + LEN_W;
    localparam int OUT_USED_W = COLOR_LSB + COLOR_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ hw/rtl/clipped_rect_span_generator.sv @@
// Clipped rectangle span generator, top level.
// Depends on crsg_pkg for command codes and stream field positions.
//
// Usage: the slave stream carries commands and row requests. tuser holds the
// kind: fill, blit or flush load a new rectangle, clipped against the screen
// set through the configuration port, and replace any unfinished one; a
// rejected command leaves the block idle. A row request (kind 3) while a
// rectangle is active produces one span item on the master stream; a row
// request while idle is dropped without a result. Commands never produce an
// item of their own.
// A span passes the stage 1 register, where its operands are captured when
// its row request is accepted, then the stage 2 register, which holds the
// products, and then the output register, which holds the final sums.
// Throughput: one item per cycle unless the receiver stalls. Clipping and
// the row counter update at the moment of acceptance, and the multipliers
// sit in their own pipeline stage, so each stage holds one item and
// advances whenever the next one is free.
// Reset (synchronous, active low) clears the configuration registers to zero,
// drops the active rectangle and empties the pipeline.
// When the receiver stalls, the output register holds its span; the earlier
// stages keep filling until all three are occupied, and only then does
// s_axis_tready fall. The user must write configuration only while the block
// is idle; the block itself does not enforce this.
`default_nettype none

module clipped_rect_span_generator #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [crsg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Command stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, lowest bit first: rect_x[15:0], rect_y[31:16], rect_w[47:32],
    // rect_h[63:48], color[95:64], source_base[143:96], source_stride[159:144]
    input  wire logic [crsg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]                        s_axis_tuser,
    // Span stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata, lowest bit first: shadow_index[23:0], device_offset[51:24],
    // source_index[99:52], span_length[112:100], span_color[144:113], zeros
    output logic [crsg_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // tuser: span_op[1:0]
    output logic [1:0]                             m_axis_tuser,
    // tlast: last_row
    output logic                                   m_axis_tlast
);

    // Width of an x coordinate, of a clipped width, of a y coordinate and of
    // a clipped height.
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int SROW_W = 17;   // cut_top plus a row count
    localparam int STRIDE_W = 15; // strictly positive signed 16-bit stride
    localparam int SHP_W = YW + WW;
    localparam int DVP_W = YW + 16;
    localparam int SRP_W = SROW_W + STRIDE_W;
    localparam int DVS_W = DVP_W + 1;

    // ---------------- configuration registers ----------------
    logic        r_enabled;
    logic [12:0] r_screen_w;
    logic [12:0] r_screen_h;
    logic [15:0] r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_screen_w <= '0;
            r_screen_h <= '0;
            r_pitch    <= '0;
        end else if (i_cfg_we) begin
            case (crsg_pkg::t_cfg_idx'(i_cfg_index))
                crsg_pkg::CFG_ENABLED: r_enabled  <= i_cfg_data[0];
                crsg_pkg::CFG_WIDTH:   r_screen_w <= i_cfg_data[12:0];
                crsg_pkg::CFG_HEIGHT:  r_screen_h <= i_cfg_data[12:0];
                crsg_pkg::CFG_PITCH:   r_pitch    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Screen size saturated to the supported maximum, in the signed domain
    // used by the clipping logic.
    logic signed [17:0] fw;
    logic signed [17:0] fh;
    assign fw = ($signed({5'b0, r_screen_w}) > 18'(MAX_WIDTH))
              ? 18'(MAX_WIDTH) : $signed({5'b0, r_screen_w});
    assign fh = ($signed({5'b0, r_screen_h}) > 18'(MAX_HEIGHT))
              ? 18'(MAX_HEIGHT) : $signed({5'b0, r_screen_h});

    // ---------------- handshake and stage advance ----------------
    logic r_s1_v, r_s2_v, r_out_v;
    logic out_en, s2_en, s1_en;
    logic in_acc;

    assign out_en        = !r_out_v || m_axis_tready;
    assign s2_en         = !r_s2_v || out_en;
    assign s1_en         = !r_s1_v || s2_en;
    assign s_axis_tready = s1_en;
    assign in_acc        = s_axis_tvalid && s1_en;

    // ---------------- input field unpacking ----------------
    crsg_pkg::t_kind    in_kind;
    logic signed [15:0] in_x, in_y, in_w, in_h, in_stride;
    logic [31:0]        in_color;
    logic [47:0]        in_base;

    assign in_kind   = crsg_pkg::t_kind'(s_axis_tuser);
    assign in_x      = s_axis_tdata[15:0];
    assign in_y      = s_axis_tdata[31:16];
    assign in_w      = s_axis_tdata[47:32];
    assign in_h      = s_axis_tdata[63:48];
    assign in_color  = s_axis_tdata[95:64];
    assign in_base   = s_axis_tdata[143:96];
    assign in_stride = s_axis_tdata[159:144];

    // ---------------- rectangle clipping ----------------
    logic signed [17:0] cl_x, cl_y, cl_w, cl_h, cl_dx, cl_dy;
    logic               cl_ok;

    always_comb begin
        cl_x  = 18'(in_x);
        cl_y  = 18'(in_y);
        cl_w  = 18'(in_w);
        cl_h  = 18'(in_h);
        cl_dx = '0;
        cl_dy = '0;
        cl_ok = r_enabled && (cl_w > 18'sd0) && (cl_h > 18'sd0);
        if (in_kind == crsg_pkg::KIND_BLIT &&
            (in_base == '0 || in_stride <= 16'sd0)) begin
            cl_ok = 1'b0;
        end
        // Trim a negative origin and remember how much was cut off.
        if (cl_x < 18'sd0) begin
            cl_dx = -cl_x;
            cl_w  = cl_w - cl_dx;
            cl_x  = '0;
        end
        if (cl_y < 18'sd0) begin
            cl_dy = -cl_y;
            cl_h  = cl_h - cl_dy;
            cl_y  = '0;
        end
        if (cl_x > fw || cl_y > fh) begin
            cl_ok = 1'b0;
        end
        // Cut back extents that run past the right or bottom edge.
        if (cl_x + cl_w > fw) begin
            cl_w = fw - cl_x;
        end
        if (cl_y + cl_h > fh) begin
            cl_h = fh - cl_y;
        end
        if (cl_w <= 18'sd0 || cl_h <= 18'sd0) begin
            cl_ok = 1'b0;
        end
    end

    // ---------------- rectangle state ----------------
    logic                r_busy;
    crsg_pkg::t_kind     r_op;
    logic [XW-1:0]       r_cx;
    logic [YW-1:0]       r_cy;
    logic [WW-1:0]       r_cw;
    logic [HW-1:0]       r_ch;
    logic [15:0]         r_cut_left;
    logic [15:0]         r_cut_top;
    logic [YW-1:0]       r_row_cnt;
    logic [31:0]         r_color;
    logic [47:0]         r_base;
    logic [STRIDE_W-1:0] r_stride;

    logic row_hit;  // a row request that produces a span
    logic row_last;

    assign row_hit  = in_acc && in_kind == crsg_pkg::KIND_ROW && r_busy;
    assign row_last = (HW'(r_row_cnt) + HW'(1)) >= r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_row_cnt <= '0;
        end else if (in_acc) begin
            if (in_kind != crsg_pkg::KIND_ROW) begin
                // Any command drops the unfinished rectangle.
                r_busy    <= cl_ok;
                r_row_cnt <= '0;
            end else if (r_busy) begin
                r_busy    <= !row_last;
                r_row_cnt <= row_last ? '0 : YW'(r_row_cnt + YW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_kind != crsg_pkg::KIND_ROW && cl_ok) begin
            r_op       <= in_kind;
            r_cx       <= cl_x[XW-1:0];
            r_cy       <= cl_y[YW-1:0];
            r_cw       <= cl_w[WW-1:0];
            r_ch       <= cl_h[HW-1:0];
            r_cut_left <= cl_dx[15:0];
            r_cut_top  <= cl_dy[15:0];
            r_color    <= in_color;
            r_base     <= in_base;
            r_stride   <= (in_kind == crsg_pkg::KIND_BLIT) ? in_stride[STRIDE_W-1:0] : '0;
        end
    end

    // ---------------- stage 1: span operands ----------------
    crsg_pkg::t_kind     r_s1_op;
    logic [YW-1:0]       r_s1_row;
    logic [SROW_W-1:0]   r_s1_srow;
    logic [XW-1:0]       r_s1_x;
    logic [47:0]         r_s1_base;
    logic [STRIDE_W-1:0] r_s1_stride;
    logic [WW-1:0]       r_s1_w;
    logic [31:0]         r_s1_color;
    logic                r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_en) begin
            r_s1_v <= row_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_op     <= r_op;
            r_s1_row    <= YW'(r_cy + r_row_cnt);
            r_s1_srow   <= SROW_W'(r_cut_top) + SROW_W'(r_row_cnt);
            r_s1_x      <= r_cx;
            r_s1_base   <= r_base + 48'(r_cut_left);
            r_s1_stride <= r_stride;
            r_s1_w      <= r_cw;
            r_s1_color  <= r_color;
            r_s1_last   <= row_last;
        end
    end

    // ---------------- stage 2: products ----------------
    crsg_pkg::t_kind r_s2_op;
    logic [SHP_W-1:0] r_s2_shp;
    logic [DVP_W-1:0] r_s2_dvp;
    logic [SRP_W-1:0] r_s2_srp;
    logic [XW-1:0]    r_s2_x;
    logic [47:0]      r_s2_base;
    logic [WW-1:0]    r_s2_w;
    logic [31:0]      r_s2_color;
    logic             r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_s2_op    <= r_s1_op;
            r_s2_shp   <= SHP_W'(r_s1_row) * SHP_W'(fw[WW-1:0]);
            r_s2_dvp   <= DVP_W'(r_s1_row) * DVP_W'(r_pitch);
            r_s2_srp   <= SRP_W'(r_s1_srow) * SRP_W'(r_s1_stride);
            r_s2_x     <= r_s1_x;
            r_s2_base  <= r_s1_base;
            r_s2_w     <= r_s1_w;
            r_s2_color <= r_s1_color;
            r_s2_last  <= r_s1_last;
        end
    end

    // ---------------- output register ----------------
    logic [crsg_pkg::SHADOW_W-1:0] n_shadow;
    logic [crsg_pkg::DEV_W-1:0]    n_dev;
    logic [crsg_pkg::SRC_W-1:0]    n_src;
    logic [crsg_pkg::COLOR_W-1:0]  n_color;

    // Each op keeps its own field; all others but shadow_index read as zero.
    always_comb begin
        n_shadow = crsg_pkg::SHADOW_W'(r_s2_shp + SHP_W'(r_s2_x));
        n_dev    = '0;
        n_src    = '0;
        n_color  = '0;
        case (r_s2_op)
            crsg_pkg::KIND_FILL:  n_color = r_s2_color;
            crsg_pkg::KIND_BLIT:  n_src   = r_s2_base + 48'(r_s2_srp);
            crsg_pkg::KIND_FLUSH: n_dev   = crsg_pkg::DEV_W'(DVS_W'(r_s2_dvp)
                                  + DVS_W'({r_s2_x, crsg_pkg::PIX_SHIFT'(0)}));
            default: ;
        endcase
    end

    logic [crsg_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [1:0]                       r_out_op;
    logic                             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_data <= crsg_pkg::OUT_TDATA_W'({n_color,
                                                 crsg_pkg::LEN_W'(r_s2_w),
                                                 n_src, n_dev, n_shadow});
            r_out_op   <= r_s2_op;
            r_out_last <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_op;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ hw/rtl/crsg_checker.sv @@
// Port-level checker for the clipped rectangle span generator, with its bind.
// Depends on crsg_pkg for field positions and op codes.
`default_nettype none

module crsg_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [crsg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic [1:0]                        m_axis_tuser,
    input wire logic                              m_axis_tlast
);

    logic [crsg_pkg::DEV_W-1:0]   dev;
    logic [crsg_pkg::SRC_W-1:0]   src;
    logic [crsg_pkg::LEN_W-1:0]   len;
    logic [crsg_pkg::COLOR_W-1:0] col;

    assign dev = m_axis_tdata[crsg_pkg::DEV_LSB +: crsg_pkg::DEV_W];
    assign src = m_axis_tdata[crsg_pkg::SRC_LSB +: crsg_pkg::SRC_W];
    assign len = m_axis_tdata[crsg_pkg::LEN_LSB +: crsg_pkg::LEN_W];
    assign col = m_axis_tdata[crsg_pkg::COLOR_LSB +: crsg_pkg::COLOR_W];

    // A held span keeps its contents until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("span changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("span valid after reset");

    // Row requests never come out as spans.
    a_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != crsg_pkg::KIND_ROW)
        else $error("invalid span op");

    // A clipped rectangle is never empty.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> len != '0)
        else $error("zero length span");

    // Only the field that belongs to the op is set.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == crsg_pkg::KIND_FILL && dev == '0 && src == '0)
        || (m_axis_tuser == crsg_pkg::KIND_BLIT && dev == '0 && col == '0)
        || (m_axis_tuser == crsg_pkg::KIND_FLUSH && src == '0 && col == '0))
        else $error("span field set for the wrong op");

endmodule

bind clipped_rect_span_generator crsg_checker u_crsg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ bench/clipped_rect_span_checker.sv @@
// Scoreboard for the clipped rectangle span generator: watches the config port and both
// streams, predicts every span item from its own model of the clipper and row walker.
// Depends on crsg_pkg for kind codes, register indexes and field positions.
`timescale 1ns / 1ps

module clipped_rect_span_checker
    import crsg_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [1:0]             m_axis_tuser,
    input  logic                   m_axis_tlast,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_spans_checked
);

    typedef struct {
        t_kind        op;
        logic [23:0]  shadow;
        logic [27:0]  dev;
        logic [47:0]  src;
        logic [12:0]  len;
        logic [31:0]  color;
        logic         last;
    } span_t;

    span_t pending_spans[$];

    // Screen settings.
    logic        scr_enabled;
    logic [12:0] scr_width;
    logic [12:0] scr_height;
    logic [15:0] scr_pitch;

    // Active rectangle.
    logic        rect_busy;
    t_kind       rect_op;
    int          rect_x, rect_y, rect_w, rect_h;
    int          cut_left, cut_top, rows_done;
    logic [31:0] held_color;
    logic [47:0] held_base;
    int          held_stride;

    function automatic int visible_width();
        return (scr_width > MAX_WIDTH) ? MAX_WIDTH : int'(scr_width);
    endfunction

    function automatic int visible_height();
        return (scr_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(scr_height);
    endfunction

    task automatic write_setting(logic [1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (t_cfg_idx'(idx))
            CFG_ENABLED: scr_enabled = value[0];
            CFG_WIDTH:   scr_width   = value[12:0];
            CFG_HEIGHT:  scr_height  = value[12:0];
            CFG_PITCH:   scr_pitch   = value[15:0];
            default: ;
        endcase
    endtask

    // Clip a fill, blit or flush against the screen. Any command drops the old rectangle,
    // whether or not the new one survives clipping.
    task automatic clip_command(t_kind kind, logic [IN_TDATA_W-1:0] d);
        int x, y, w, h, dx, dy, stride, fw, fh;
        logic [47:0] base;
        x      = $signed(d[15:0]);
        y      = $signed(d[31:16]);
        w      = $signed(d[47:32]);
        h      = $signed(d[63:48]);
        base   = d[143:96];
        stride = $signed(d[159:144]);
        fw     = visible_width();
        fh     = visible_height();
        dx     = 0;
        dy     = 0;
        rect_busy = 1'b0;
        if (kind == KIND_BLIT && (base == 48'd0 || stride <= 0)) return;
        if (!scr_enabled || w <= 0 || h <= 0) return;
        if (x < 0) begin
            dx = -x;
            w  = w - dx;
            x  = 0;
        end
        if (y < 0) begin
            dy = -y;
            h  = h - dy;
            y  = 0;
        end
        if (x > fw || y > fh) return;
        if (x + w > fw) w = fw - x;
        if (y + h > fh) h = fh - y;
        if (w <= 0 || h <= 0) return;
        rect_busy   = 1'b1;
        rect_op     = kind;
        rect_x      = x;
        rect_y      = y;
        rect_w      = w;
        rect_h      = h;
        cut_left    = dx;
        cut_top     = dy;
        rows_done   = 0;
        held_color  = d[95:64];
        held_base   = base;
        held_stride = (kind == KIND_BLIT) ? stride : 0;
    endtask

    // Build the span of the current row and step the row counter.
    task automatic next_row_span(output span_t sp);
        int row;
        longint unsigned wide;
        row       = rect_y + rows_done;
        sp.op     = rect_op;
        sp.shadow = 24'(row * visible_width() + rect_x);
        sp.dev    = '0;
        sp.src    = '0;
        sp.color  = '0;
        case (rect_op)
            KIND_FILL: sp.color = held_color;
            KIND_BLIT: begin
                wide = longint'(held_base)
                     + longint'(cut_top + rows_done) * longint'(held_stride)
                     + longint'(cut_left);
                sp.src = wide[47:0];
            end
            default: begin
                wide = longint'(row) * longint'(scr_pitch)
                     + longint'(BYTES_PER_PIXEL * rect_x);
                sp.dev = wide[27:0];
            end
        endcase
        sp.len  = 13'(rect_w);
        sp.last = (rows_done + 1 >= rect_h);
        rows_done++;
        if (rows_done >= rect_h) begin
            rect_busy = 1'b0;
            rows_done = 0;
        end
    endtask

    task automatic compare_span();
        span_t want;
        if (pending_spans.size() == 0) begin
            $error("unexpected span item: shadow_index %0h", m_axis_tdata[SHADOW_LSB +: SHADOW_W]);
            o_fail_count++;
            return;
        end
        want = pending_spans.pop_front();
        if (m_axis_tuser !== want.op) begin
            $error("span_op: expected %0d, got %0d", want.op, m_axis_tuser);
            o_fail_count++;
        end
        if (m_axis_tdata[SHADOW_LSB +: SHADOW_W] !== want.shadow) begin
            $error("shadow_index: expected %0h, got %0h", want.shadow,
                   m_axis_tdata[SHADOW_LSB +: SHADOW_W]);
            o_fail_count++;
        end
        if (m_axis_tdata[DEV_LSB +: DEV_W] !== want.dev) begin
            $error("device_offset: expected %0h, got %0h", want.dev,
                   m_axis_tdata[DEV_LSB +: DEV_W]);
            o_fail_count++;
        end
        if (m_axis_tdata[SRC_LSB +: SRC_W] !== want.src) begin
            $error("source_index: expected %0h, got %0h", want.src,
                   m_axis_tdata[SRC_LSB +: SRC_W]);
            o_fail_count++;
        end
        if (m_axis_tdata[LEN_LSB +: LEN_W] !== want.len) begin
            $error("span_length: expected %0d, got %0d", want.len,
                   m_axis_tdata[LEN_LSB +: LEN_W]);
            o_fail_count++;
        end
        if (m_axis_tdata[COLOR_LSB +: COLOR_W] !== want.color) begin
            $error("span_color: expected %0h, got %0h", want.color,
                   m_axis_tdata[COLOR_LSB +: COLOR_W]);
            o_fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
            $error("last_row: expected %0b, got %0b", want.last, m_axis_tlast);
            o_fail_count++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] !== '0) begin
            $error("padding: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W]);
            o_fail_count++;
        end
        o_spans_checked++;
    endtask

    always @(posedge i_clk) begin
        span_t sp;
        if (!i_rst_n) begin
            scr_enabled     = 1'b0;
            scr_width       = '0;
            scr_height      = '0;
            scr_pitch       = '0;
            rect_busy       = 1'b0;
            rect_op         = KIND_FILL;
            rows_done       = 0;
            o_fail_count    = 0;
            o_spans_checked = 0;
            pending_spans.delete();
        end else begin
            // Spans leave after their row item is accepted, so pop before push.
            if (m_axis_tvalid && m_axis_tready) compare_span();
            if (i_cfg_we) write_setting(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                if (t_kind'(s_axis_tuser) != KIND_ROW) begin
                    clip_command(t_kind'(s_axis_tuser), s_axis_tdata);
                end else if (rect_busy) begin
                    next_row_span(sp);
                    pending_spans.push_back(sp);
                end
            end
        end
        o_pending = pending_spans.size();
    end

endmodule

@@ bench/clipped_rect_span_generator_tb.sv @@
// Top of the span generator bench: clock, reset, config writes, command and row stimulus,
// random stalls on both streams and the final verdict.
// Depends on crsg_pkg, clipped_rect_span_generator and clipped_rect_span_checker.
`timescale 1ns / 1ps

module clipped_rect_span_generator_tb;
    import crsg_pkg::*;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_SCREENS = 7;
    localparam int FULL_ROWS   = 64;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [1:0]             i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // rect_x, rect_y, rect_w, rect_h, color, source_base, source_stride (lowest bit first)
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // kind
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // shadow_index, device_offset, source_index, span_length, span_color, zero padding
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // span_op
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    int fail_count;
    int spans_pending;
    int spans_checked;
    int cycle_count = 0;
    int commands_sent;
    int rows_sent;

    // no_idle switches off every random gap on both streams. hold_request asks the
    // receiver for one long stall; it raises output_held while the stall lasts.
    bit no_idle;
    bit hold_request;
    bit output_held;

    // Screen settings walked by the random part: a plain VGA-like screen, oversize
    // registers that must saturate, a one-pixel screen, the full maximum, a disabled
    // screen, a zero-sized screen and an odd-sized one.
    int screen_w[NUM_SCREENS]  = '{640, 8191, 1, 4096, 320, 0, 333};
    int screen_h[NUM_SCREENS]  = '{480, 8191, 1, 4096, 200, 0, 17};
    int screen_p[NUM_SCREENS]  = '{2560, 65535, 0, 16384, 1280, 4, 1337};
    int screen_en[NUM_SCREENS] = '{1, 1, 1, 1, 0, 1, 1};
    int budget[NUM_SCREENS]    = '{400, 350, 150, 350, 60, 60, 350};

    clipped_rect_span_generator #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    clipped_rect_span_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) span_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (spans_pending),
        .o_spans_checked (spans_checked)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a span that never shows up ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** clipped_rect_span_generator: FAILED **");
            $finish;
        end
    end

    // Idle length for either stream: mostly none, often a few cycles, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver. Ready comes in runs of random length separated by random gaps. On request
    // it holds ready low for a long stretch so the pipeline fills and the input stalls.
    initial begin
        forever begin
            if (hold_request) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                hold_request = 1'b0;
                output_held  = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                output_held  = 1'b0;
            end else if (no_idle) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
                if (pick_gap() > 0) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                    repeat (pick_gap()) @(negedge i_clk);
                end
            end
        end
    end

    // Offer one item after a random gap and return once it has been taken. Valid stays high
    // afterwards so back-to-back items need no extra step.
    task automatic send_item(t_kind kind, logic [15:0] x, logic [15:0] y, logic [15:0] w,
                             logic [15:0] h, logic [31:0] color, logic [47:0] base,
                             logic [15:0] stride);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stride, base, color, h, w, y, x};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_ROW) rows_sent++;
        else commands_sent++;
    endtask

    // A row request; its other fields are junk that the block must ignore.
    task automatic send_row();
        send_item(KIND_ROW, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  32'($urandom), {16'($urandom), 32'($urandom)}, 16'($urandom));
    endtask

    // Stop offering items, let every expected span drain and give the pipeline a few more
    // cycles, since commands and idle row requests leave nothing to wait for.
    task automatic drain_outputs();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (spans_pending == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_screen(int en, int w, int h, int pitch);
        write_reg(CFG_ENABLED, en);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_PITCH, pitch);
    endtask

    // Left or top edge: mostly on screen, some negative so the origin is trimmed, a few at
    // or just past the far edge.
    function automatic int pick_origin(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return -int'($urandom_range(1, 300));
        if (r < 17) return lim + int'($urandom_range(0, 3));
        return (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
    endfunction

    // Width: usually inside the screen, sometimes past it so the right edge is cut back.
    function automatic int pick_extent(int lim);
        if ($urandom_range(0, 99) < 8) return lim + int'($urandom_range(0, 100));
        return $urandom_range(1, lim / 3 + 2);
    endfunction

    // Height drives how many row requests follow, so it is kept mostly small.
    function automatic int pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 6);
        if (r < 97) return $urandom_range(7, 24);
        return $urandom_range(25, 60);
    endfunction

    // Random traffic for one screen setting. Most of it is a command followed by the row
    // requests for its height; some sequences are cut short by the next command, some run
    // past the end, and one draw in ten is a single fully random noise item.
    task automatic run_random(int items, int fw, int fh);
        int done_items;
        int r;
        int h;
        int rows;
        t_kind kind;
        logic [47:0] base;
        logic [15:0] stride;
        done_items = 0;
        while (done_items < items) begin
            if ($urandom_range(0, 99) < 10) begin
                send_item(t_kind'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 32'($urandom),
                          {16'($urandom), 32'($urandom)}, 16'($urandom));
                done_items++;
            end else begin
                kind = t_kind'($urandom_range(0, 2));
                h    = pick_height();
                base = ($urandom_range(0, 19) == 0) ? 48'd0 : {16'($urandom), 32'($urandom)};
                r    = $urandom_range(0, 19);
                if (r == 0) stride = 16'd0;
                else if (r == 1) stride = 16'($urandom) | 16'h8000;
                else stride = 16'($urandom_range(1, 32767));
                send_item(kind, 16'(pick_origin(fw)), 16'(pick_origin(fh)),
                          16'(pick_extent(fw)), 16'(h), 32'($urandom), base, stride);
                done_items++;
                r = $urandom_range(0, 99);
                if (r < 75) rows = h;
                else if (r < 90) rows = $urandom_range(0, h - 1);
                else rows = h + $urandom_range(1, 3);
                for (int i = 0; i < rows; i++) begin
                    send_row();
                    if (i < h) done_items++;
                end
            end
        end
    endtask

    initial begin
        int fw;
        int fh;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        commands_sent = 0;
        rows_sent     = 0;
        no_idle       = 1'b0;
        hold_request  = 1'b0;
        output_held   = 1'b0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on a 640x480 screen.
        set_screen(1, 640, 480, 2560);
        // A row request with no rectangle loaded yields nothing.
        send_row();
        // Plain fill of two rows, then one extra row request once it is done.
        send_item(KIND_FILL, 16'd10, 16'd20, 16'd5, 16'd2, 32'hDEADBEEF, 48'd0, 16'd0);
        send_row();
        send_row();
        send_row();
        // Blit with a negative origin: left and top cuts feed the source index.
        send_item(KIND_BLIT, -16'sd3, -16'sd2, 16'd10, 16'd4, 32'h0, 48'h1000, 16'd100);
        send_row();
        send_row();
        // Flush hanging off the bottom-right corner, cancelled after one row by a blit
        // that is rejected for its zero source base.
        send_item(KIND_FLUSH, 16'd630, 16'd470, 16'd100, 16'd100, 32'h0, 48'd0, 16'd0);
        send_row();
        send_item(KIND_BLIT, 16'd0, 16'd0, 16'd4, 16'd4, 32'h0, 48'd0, 16'd1);
        send_row();
        // Blits with a zero and a negative stride are rejected.
        send_item(KIND_BLIT, 16'd0, 16'd0, 16'd4, 16'd4, 32'h0, 48'h55, 16'd0);
        send_item(KIND_BLIT, 16'd0, 16'd0, 16'd4, 16'd4, 32'h0, 48'h55, -16'sd5);
        send_row();
        // Empty extents and origins on the right and bottom edges are rejected.
        send_item(KIND_FILL, 16'd0, 16'd0, 16'd0, 16'd4, 32'h1, 48'd0, 16'd0);
        send_item(KIND_FILL, 16'd0, 16'd0, 16'd4, 16'hFFFF, 32'h1, 48'd0, 16'd0);
        send_item(KIND_FILL, 16'd640, 16'd0, 16'd4, 16'd4, 32'h1, 48'd0, 16'd0);
        send_item(KIND_FILL, 16'd0, 16'd480, 16'd4, 16'd4, 32'h1, 48'd0, 16'd0);
        // Source index wraps past the top of the 48-bit space with the largest stride.
        send_item(KIND_BLIT, 16'd0, -16'sd100, 16'd3, 16'd102, 32'h0,
                  48'hFFFF_FFFF_FFF0, 16'd32767);
        send_row();
        send_row();
        // Most negative origin leaves nothing; a huge flush is cut back to the screen width.
        send_item(KIND_FILL, 16'h8000, 16'd0, 16'd32767, 16'd1, 32'hFFFFFFFF, 48'd0, 16'd0);
        send_item(KIND_FLUSH, 16'd0, 16'd0, 16'd32767, 16'd1, 32'h0, 48'd0, 16'd0);
        send_row();
        drain_outputs();

        // Long output stall: row requests keep coming back to back until the pipeline is
        // full and the input stalls, then the rest of the rectangle is walked.
        send_item(KIND_FILL, 16'd3, 16'd7, 16'd8, 16'd100, 32'hA5A5_5A5A, 48'd0, 16'd0);
        hold_request = 1'b1;
        wait (output_held);
        no_idle = 1'b1;
        repeat (40) send_row();
        no_idle = 1'b0;
        repeat (60) send_row();
        drain_outputs();

        for (int s = 0; s < NUM_SCREENS; s++) begin
            set_screen(screen_en[s], screen_w[s], screen_h[s], screen_p[s]);
            fw = (screen_w[s] > MAX_WIDTH) ? MAX_WIDTH : screen_w[s];
            fh = (screen_h[s] > MAX_HEIGHT) ? MAX_HEIGHT : screen_h[s];
            // The one-pixel screen runs without any idling on either side.
            no_idle = (screen_w[s] == 1);
            // On the full-size screen, walk one oversize fill over the bottom rows at full
            // rate, so the height is cut back at the last row of the screen.
            if (screen_w[s] == MAX_WIDTH) begin
                no_idle = 1'b1;
                send_item(KIND_FILL, 16'd0, 16'(MAX_HEIGHT - FULL_ROWS), 16'd32767,
                          16'd32767, 32'h1234_5678, 48'd0, 16'd0);
                repeat (FULL_ROWS) send_row();
                no_idle = 1'b0;
            end
            run_random(budget[s], fw, fh);
            no_idle = 1'b0;
            drain_outputs();
        end

        repeat (10) @(posedge i_clk);
        $display("Run covered %0d commands and %0d row requests over %0d screen settings,",
                 commands_sent, rows_sent, NUM_SCREENS + 1);
        $display("including saturated, empty and disabled screens; %0d spans compared.",
                 spans_checked);
        if (fail_count == 0) begin
            $display("** clipped_rect_span_generator: PASSED **");
        end else begin
            $display("** clipped_rect_span_generator: FAILED **");
        end
        $finish;
    end

endmodule
